>>> rtl/core/tacp_pkg.sv
// Shared types, constants and helper functions for the touch averager
// and character-cell mapper. No dependencies; used by every module of the block.
package tacp_pkg;

    localparam int SAMPLE_W = 12;
    localparam int SUM_W    = 14;
    localparam int COUNT_W  = 8;
    localparam int MODE_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int DIV_STEPS  = SAMPLE_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_TOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_BOTTOM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ORIENT_MODE = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [SAMPLE_W-1:0] EDGE_LEFT_RST   = 12'd0;
    localparam logic [SAMPLE_W-1:0] EDGE_RIGHT_RST  = 12'd4095;
    localparam logic [SAMPLE_W-1:0] EDGE_TOP_RST    = 12'd0;
    localparam logic [SAMPLE_W-1:0] EDGE_BOTTOM_RST = 12'd4095;
    localparam logic [COUNT_W-1:0]  COLUMNS_RST     = 8'd16;
    localparam logic [COUNT_W-1:0]  ROWS_RST        = 8'd8;
    localparam logic [MODE_W-1:0]   ORIENT_MODE_RST = 3'd0;

    // Bits of the orientation mode register.
    localparam int MODE_SWAP   = 0;
    localparam int MODE_FLIP_H = 1;
    localparam int MODE_FLIP_V = 2;

    // Everything needed to map one averaged axis value to a cell.
    typedef struct packed {
        logic [SAMPLE_W-1:0] pos;
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] hi;
        logic [COUNT_W-1:0]  n;
        logic                flip;
    } axis_t;

    // Span between the calibrated edges; inverted or equal edges give zero.
    function automatic logic [SAMPLE_W-1:0] axis_span(input axis_t a);
        logic [SAMPLE_W-1:0] span;
        span = (a.hi > a.lo) ? (a.hi - a.lo) : '0;
        return span;
    endfunction

    // Clamp the position to the edges, then measure from the start edge,
    // or from the far edge when the axis is flipped.
    function automatic logic [SAMPLE_W-1:0] axis_offset(input axis_t a);
        logic [SAMPLE_W-1:0] p1;
        logic [SAMPLE_W-1:0] p2;
        logic [SAMPLE_W-1:0] off;
        p1 = (a.pos < a.lo) ? a.lo : a.pos;
        p2 = (p1 > a.hi) ? a.hi : p1;
        if (a.flip)
        begin
            off = (a.hi > p2) ? (a.hi - p2) : '0;
        end
        else
        begin
            off = (p2 > a.lo) ? (p2 - a.lo) : '0;
        end
        return off;
    endfunction

    // A zero cell count behaves as a count of one.
    function automatic logic [COUNT_W-1:0] count_fix(input logic [COUNT_W-1:0] c);
        logic [COUNT_W-1:0] n;
        n = (c == '0) ? COUNT_W'(1) : c;
        return n;
    endfunction

endpackage

>>> rtl/core/tacp_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on tacp_pkg for widths; the divisor must be nonzero.
module tacp_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [tacp_pkg::SAMPLE_W-1:0] dividend,
    input  logic [tacp_pkg::SAMPLE_W-1:0] divisor,
    output logic                         done,
    output logic [tacp_pkg::SAMPLE_W-1:0] quotient
);

    logic [tacp_pkg::SAMPLE_W-1:0]  rem_reg;
    logic [tacp_pkg::SAMPLE_W-1:0]  quo_reg;
    logic [tacp_pkg::SAMPLE_W-1:0]  dsr_reg;
    logic [tacp_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    logic [tacp_pkg::SAMPLE_W:0] shifted;
    logic [tacp_pkg::SAMPLE_W:0] trial;
    logic                        last_step;

    // The remainder stays below the divisor, so the trial difference
    // always fits with one sign bit.
    assign shifted = {rem_reg, quo_reg[tacp_pkg::SAMPLE_W-1]};
    assign trial   = shifted - {1'b0, dsr_reg};

    assign last_step = !start && busy_reg && (cnt_reg == tacp_pkg::DIV_CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= tacp_pkg::DIV_CNT_W'(tacp_pkg::DIV_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[tacp_pkg::SAMPLE_W])
            begin
                rem_reg <= trial[tacp_pkg::SAMPLE_W-1:0];
                quo_reg <= {quo_reg[tacp_pkg::SAMPLE_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[tacp_pkg::SAMPLE_W-1:0];
                quo_reg <= {quo_reg[tacp_pkg::SAMPLE_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/core/touch_average_and_char_position.sv
// Top level of the touch averager and character-cell mapper.
// Depends on tacp_pkg and instantiates the shared divider tacp_div.

// The block sums raw 12-bit X/Y touch samples in groups of four. The first
// three items of a group give no result. The fourth item yields one result
// item: both averages (sum divided by four, truncated) and a 1-based
// character column and row, each clamped to the calibrated edges and to
// the cell count. Orientation mode bit 0 swaps the axes, bit 1 flips the
// column and bit 2 flips the row, measuring from the far edge. After the
// fourth item the input stalls while a single divider that makes one
// quotient bit per cycle runs four divisions in turn (column factor,
// column quotient, row factor, row quotient), and then while the result
// moves into the output register. If the previous result still waits
// untaken in the output register at that point, the block holds the new
// one and keeps stalling until it is taken; a finished result waiting there
// does not stall new items of the next group otherwise. Configuration writes
// are meant to occur while the block is idle.
module touch_average_and_char_position
(
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration write port.
    input  logic                           cfg_we,
    input  logic [tacp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tacp_pkg::CFG_DATA_W-1:0] cfg_data,
    // Sample input channel.
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [tacp_pkg::SAMPLE_W-1:0]   sample_x,
    input  logic [tacp_pkg::SAMPLE_W-1:0]   sample_y,
    // Result output channel.
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [tacp_pkg::COUNT_W-1:0]    cell_col,
    output logic [tacp_pkg::COUNT_W-1:0]    cell_row,
    output logic [tacp_pkg::SAMPLE_W-1:0]   avg_x,
    output logic [tacp_pkg::SAMPLE_W-1:0]   avg_y
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_FAC_C,
        ST_Q_C,
        ST_FAC_R,
        ST_Q_R,
        ST_OUT
    } state_t;

    // Configuration registers.
    logic [tacp_pkg::SAMPLE_W-1:0] edge_left_reg;
    logic [tacp_pkg::SAMPLE_W-1:0] edge_right_reg;
    logic [tacp_pkg::SAMPLE_W-1:0] edge_top_reg;
    logic [tacp_pkg::SAMPLE_W-1:0] edge_bottom_reg;
    logic [tacp_pkg::COUNT_W-1:0]  columns_reg;
    logic [tacp_pkg::COUNT_W-1:0]  rows_reg;
    logic [tacp_pkg::MODE_W-1:0]   orient_mode_reg;

    // Accumulator.
    logic [tacp_pkg::SUM_W-1:0] sum_x_reg;
    logic [tacp_pkg::SUM_W-1:0] sum_y_reg;
    logic [1:0]                 sample_count_reg;
    logic [tacp_pkg::SUM_W-1:0] sum_x_next;
    logic [tacp_pkg::SUM_W-1:0] sum_y_next;

    // Sequencer and working registers.
    state_t                         state_reg;
    logic                           div_start_reg;
    tacp_pkg::axis_t                col_axis_reg;
    tacp_pkg::axis_t                row_axis_reg;
    tacp_pkg::axis_t                col_axis_next;
    tacp_pkg::axis_t                row_axis_next;
    logic [tacp_pkg::SAMPLE_W-1:0]  factor_reg;
    logic [tacp_pkg::COUNT_W-1:0]   col_cell_reg;
    logic [tacp_pkg::COUNT_W-1:0]   row_cell_reg;
    logic [tacp_pkg::SAMPLE_W-1:0]  avg_x_work_reg;
    logic [tacp_pkg::SAMPLE_W-1:0]  avg_y_work_reg;

    // Output register.
    logic                           out_valid_reg;
    logic [tacp_pkg::COUNT_W-1:0]   cell_col_reg;
    logic [tacp_pkg::COUNT_W-1:0]   cell_row_reg;
    logic [tacp_pkg::SAMPLE_W-1:0]  avg_x_reg;
    logic [tacp_pkg::SAMPLE_W-1:0]  avg_y_reg;

    logic                           in_accept;
    logic                           group_end;
    logic [tacp_pkg::SAMPLE_W-1:0]  avg_x_now;
    logic [tacp_pkg::SAMPLE_W-1:0]  avg_y_now;
    tacp_pkg::axis_t                x_axis;
    tacp_pkg::axis_t                y_axis;
    tacp_pkg::axis_t                cur_axis;
    logic [tacp_pkg::SAMPLE_W-1:0]  div_dividend;
    logic [tacp_pkg::SAMPLE_W-1:0]  div_divisor;
    logic                           div_done;
    logic [tacp_pkg::SAMPLE_W-1:0]  div_quotient;
    logic [tacp_pkg::SAMPLE_W-1:0]  factor_fixed;
    logic [tacp_pkg::COUNT_W-1:0]   cell_now;
    logic                           out_free;

    // ------------------------------------------------------------------
    // Configuration writes. Indexes beyond the register list are ignored.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_left_reg   <= tacp_pkg::EDGE_LEFT_RST;
            edge_right_reg  <= tacp_pkg::EDGE_RIGHT_RST;
            edge_top_reg    <= tacp_pkg::EDGE_TOP_RST;
            edge_bottom_reg <= tacp_pkg::EDGE_BOTTOM_RST;
            columns_reg     <= tacp_pkg::COLUMNS_RST;
            rows_reg        <= tacp_pkg::ROWS_RST;
            orient_mode_reg <= tacp_pkg::ORIENT_MODE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tacp_pkg::REG_EDGE_LEFT:   edge_left_reg   <= cfg_data;
                tacp_pkg::REG_EDGE_RIGHT:  edge_right_reg  <= cfg_data;
                tacp_pkg::REG_EDGE_TOP:    edge_top_reg    <= cfg_data;
                tacp_pkg::REG_EDGE_BOTTOM: edge_bottom_reg <= cfg_data;
                tacp_pkg::REG_COLUMNS:
                    columns_reg <= cfg_data[tacp_pkg::COUNT_W-1:0];
                tacp_pkg::REG_ROWS:
                    rows_reg <= cfg_data[tacp_pkg::COUNT_W-1:0];
                tacp_pkg::REG_ORIENT_MODE:
                    orient_mode_reg <= cfg_data[tacp_pkg::MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input side. Items are taken only while the sequencer is idle.
    // ------------------------------------------------------------------
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign group_end = (sample_count_reg == 2'd3);

    assign sum_x_next = sum_x_reg + {2'b00, sample_x};
    assign sum_y_next = sum_y_reg + {2'b00, sample_y};
    assign avg_x_now  = sum_x_next[tacp_pkg::SUM_W-1:2];
    assign avg_y_now  = sum_y_next[tacp_pkg::SUM_W-1:2];

    // Axis descriptions built from the fresh averages and the current
    // calibration; the swap bit decides which one feeds the column.
    always_comb
    begin
        x_axis.pos  = avg_x_now;
        x_axis.lo   = edge_left_reg;
        x_axis.hi   = edge_right_reg;
        x_axis.n    = '0;
        x_axis.flip = 1'b0;
        y_axis.pos  = avg_y_now;
        y_axis.lo   = edge_top_reg;
        y_axis.hi   = edge_bottom_reg;
        y_axis.n    = '0;
        y_axis.flip = 1'b0;
    end

    // The column always takes the column count and the horizontal flip, the
    // row the row count and the vertical flip, whichever axis feeds them.
    always_comb
    begin
        if (orient_mode_reg[tacp_pkg::MODE_SWAP])
        begin
            col_axis_next = y_axis;
            row_axis_next = x_axis;
        end
        else
        begin
            col_axis_next = x_axis;
            row_axis_next = y_axis;
        end
        col_axis_next.n    = tacp_pkg::count_fix(columns_reg);
        col_axis_next.flip = orient_mode_reg[tacp_pkg::MODE_FLIP_H];
        row_axis_next.n    = tacp_pkg::count_fix(rows_reg);
        row_axis_next.flip = orient_mode_reg[tacp_pkg::MODE_FLIP_V];
    end

    // ------------------------------------------------------------------
    // Shared divider. Its operands follow the sequencer state; the divider
    // captures them in the cycle that start is high.
    // ------------------------------------------------------------------
    always_comb
    begin
        cur_axis = ((state_reg == ST_FAC_C) || (state_reg == ST_Q_C))
                   ? col_axis_reg : row_axis_reg;
        if ((state_reg == ST_FAC_C) || (state_reg == ST_FAC_R))
        begin
            div_dividend = tacp_pkg::axis_span(cur_axis);
            div_divisor  = {{(tacp_pkg::SAMPLE_W-tacp_pkg::COUNT_W){1'b0}}, cur_axis.n};
        end
        else
        begin
            div_dividend = tacp_pkg::axis_offset(cur_axis);
            div_divisor  = factor_reg;
        end
    end

    tacp_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // A zero factor is forced to one so the offset division is defined.
    assign factor_fixed = (div_quotient == '0) ? tacp_pkg::SAMPLE_W'(1) : div_quotient;

    // Cell is quotient plus one, saturated at the count.
    assign cell_now =
        (div_quotient >= {{(tacp_pkg::SAMPLE_W-tacp_pkg::COUNT_W){1'b0}}, cur_axis.n})
        ? cur_axis.n
        : (div_quotient[tacp_pkg::COUNT_W-1:0] + 1'b1);

    // The output register can take a new result when it is empty or
    // when its current result is taken in this cycle.
    assign out_free = !out_valid_reg || !out_stall;

    // ------------------------------------------------------------------
    // Sequencer, accumulator and output register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            div_start_reg    <= 1'b0;
            sum_x_reg        <= '0;
            sum_y_reg        <= '0;
            sample_count_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            // A new result is loaded, or the current one leaves.
            if ((state_reg == ST_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    div_start_reg <= in_accept && group_end;
                    if (in_accept)
                    begin
                        if (group_end)
                        begin
                            sum_x_reg        <= '0;
                            sum_y_reg        <= '0;
                            sample_count_reg <= '0;
                            state_reg        <= ST_FAC_C;
                        end
                        else
                        begin
                            sum_x_reg        <= sum_x_next;
                            sum_y_reg        <= sum_y_next;
                            sample_count_reg <= sample_count_reg + 1'b1;
                        end
                    end
                end
                ST_FAC_C:
                begin
                    div_start_reg <= div_done;
                    if (div_done)
                    begin
                        state_reg <= ST_Q_C;
                    end
                end
                ST_Q_C:
                begin
                    div_start_reg <= div_done;
                    if (div_done)
                    begin
                        state_reg <= ST_FAC_R;
                    end
                end
                ST_FAC_R:
                begin
                    div_start_reg <= div_done;
                    if (div_done)
                    begin
                        state_reg <= ST_Q_R;
                    end
                end
                ST_Q_R:
                begin
                    div_start_reg <= 1'b0;
                    if (div_done)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    div_start_reg <= 1'b0;
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    div_start_reg <= 1'b0;
                    state_reg     <= ST_IDLE;
                end
            endcase
        end
    end

    // Working and output payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept && group_end)
        begin
            avg_x_work_reg <= avg_x_now;
            avg_y_work_reg <= avg_y_now;
            col_axis_reg   <= col_axis_next;
            row_axis_reg   <= row_axis_next;
        end

        if (div_done && ((state_reg == ST_FAC_C) || (state_reg == ST_FAC_R)))
        begin
            factor_reg <= factor_fixed;
        end
        if (div_done && (state_reg == ST_Q_C))
        begin
            col_cell_reg <= cell_now;
        end
        if (div_done && (state_reg == ST_Q_R))
        begin
            row_cell_reg <= cell_now;
        end

        if ((state_reg == ST_OUT) && out_free)
        begin
            cell_col_reg <= col_cell_reg;
            cell_row_reg <= row_cell_reg;
            avg_x_reg    <= avg_x_work_reg;
            avg_y_reg    <= avg_y_work_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign cell_col  = cell_col_reg;
    assign cell_row  = cell_row_reg;
    assign avg_x     = avg_x_reg;
    assign avg_y     = avg_y_reg;

endmodule
